/* rtl/core/mmvt_pkg.sv */
// Package for the model-matrix vertex transform: types, codes, constants,
// CORDIC arctangent table and fixed-point helpers. No dependencies.
`default_nettype none
package mmvt_pkg;
   localparam int FRAC_BITS   = 16;
   localparam int ANGLE_BITS  = 16;
   localparam int CORDIC_STEPS = 24;
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sh026DD3B6A;
   localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
   localparam logic [3:0] NUM_PARAMS = 4'd9;

   localparam logic FUNC_SET       = 1'b0;
   localparam logic FUNC_TRANSFORM = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CD_INIT, ST_CORDIC, ST_SC_STORE, ST_ROT, ST_SCALE, ST_XFORM, ST_XF_ROW,
      ST_OUT
   } state_type;

   function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
      case (i)
         5'd0:  atan_turns = 34'h020000000;
         5'd1:  atan_turns = 34'h012E4051E;
         5'd2:  atan_turns = 34'h009FB385B;
         5'd3:  atan_turns = 34'h0051111D4;
         5'd4:  atan_turns = 34'h0028B0D43;
         5'd5:  atan_turns = 34'h00145D7E1;
         5'd6:  atan_turns = 34'h000A2F61E;
         5'd7:  atan_turns = 34'h000517C55;
         5'd8:  atan_turns = 34'h00028BE53;
         5'd9:  atan_turns = 34'h000145F2F;
         5'd10: atan_turns = 34'h0000A2F98;
         5'd11: atan_turns = 34'h0000517CC;
         5'd12: atan_turns = 34'h000028BE6;
         5'd13: atan_turns = 34'h0000145F3;
         5'd14: atan_turns = 34'h00000A2F9;
         5'd15: atan_turns = 34'h00000517C;
         5'd16: atan_turns = 34'h0000028BE;
         5'd17: atan_turns = 34'h00000145F;
         5'd18: atan_turns = 34'h000000A2F;
         5'd19: atan_turns = 34'h000000517;
         5'd20: atan_turns = 34'h00000028B;
         5'd21: atan_turns = 34'h000000145;
         5'd22: atan_turns = 34'h0000000A2;
         5'd23: atan_turns = 34'h000000051;
         default: atan_turns = '0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sh0007FFFFFFF)       sat32 = 32'sh7FFFFFFF;
      else if (v < -50'sh00080000000) sat32 = 32'sh80000000;
      else                            sat32 = v[31:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/core/model_matrix_vertex_transform.sv */
// Model-matrix vertex transform top level: parameter store, CORDIC sine/cosine,
// one shared 32x33 multiplier under a sequencer, matrix and output register.
// Depends on mmvt_pkg.
//
//  channel | dir | tdata (low to high)                         | tuser
//  req_    | in  | param_sel[3:0] param_value vec_x..vec_w     | func
//  rsp_    | out | out_x out_y out_z out_w                     | -
//
// Transform item: for each matrix row the products over all columns are accumulated,
// then rounded into the row result; the result is registered after the last row and
// the next item is taken the cycle after the result leaves. Set item: for each axis a
// CORDIC load, 24 steps and a store, then the rotation and scale multiplies.
// Reset gives scale one and identity matrix. req_tready is low while busy and
// while a result waits in the output register.
`default_nettype none
module model_matrix_vertex_transform (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [167:0]  req_tdata,  // param_sel[3:0], param_value, vec_x..vec_w, pad
   input  wire logic          req_tuser,  // func
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata   // out_x, out_y, out_z, out_w
);
   import mmvt_pkg::*;

   state_type state_ff, state_in;
   logic signed [31:0] prm_ff [9];
   logic signed [31:0] mtx_ff [12];
   logic signed [31:0] vec_ff [4];
   logic signed [31:0] res_ff [4];
   logic signed [31:0] sc_ff [6];      // cx sx cy sy cz sz
   logic signed [31:0] rot_ff [9];
   logic signed [31:0] tmp_ff;
   logic [1:0]  axis_ff;
   logic [4:0]  cnt_ff;
   logic [1:0]  q_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic signed [49:0] hi_ff, lo_ff;
   logic        rv_ff;

   logic        acc;
   logic [3:0]  sel;
   logic [3:0]  ridx;
   logic [1:0]  row, col;
   logic signed [31:0] ma;
   logic signed [32:0] mb;
   logic signed [64:0] prod;
   logic signed [47:0] pq;
   logic signed [31:0] ang;
   logic [31:0] aw, rw;
   logic [1:0]  qn;
   logic signed [33:0] dx, dy, at, cc, ss;
   logic signed [31:0] crd_c, crd_s;

   assign acc = req_tvalid && req_tready;
   assign sel = req_tdata[3:0];
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
   assign row = cnt_ff[3:2];
   assign col = cnt_ff[1:0];

   // angle split into quarter turn and signed remainder
   assign ang = prm_ff[4'd3 + {2'd0, axis_ff}];
   assign aw  = {ang[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
   assign qn  = 2'((aw + 32'h20000000) >> 30);
   assign rw  = aw - {qn, 30'd0};

   assign dx = cy_ff >>> cnt_ff;
   assign dy = cx_ff >>> cnt_ff;
   assign at = atan_turns(cnt_ff);

   always_comb begin
      case (q_ff)
         2'd0:    begin cc = cx_ff;  ss = cy_ff;  end
         2'd1:    begin cc = -cy_ff; ss = cx_ff;  end
         2'd2:    begin cc = -cx_ff; ss = -cy_ff; end
         default: begin cc = cy_ff;  ss = -cx_ff; end
      endcase
   end
   assign crd_c = 32'((cc + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
   assign crd_s = 32'((ss + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

   // operand mux: rotation by cnt, tmp holds first-pair product; scale; transform
   always_comb begin
      ma = '0;
      mb = '0;
      ridx = 4'd0;
      case (state_ff)
         ST_ROT: begin
            case (cnt_ff)
               5'd0:  begin ma = sc_ff[4]; mb = 33'(sc_ff[2]); end // cz*cy
               5'd1:  begin ma = sc_ff[4]; mb = 33'(sc_ff[3]); end // cz*sy
               5'd2:  begin ma = tmp_ff;   mb = 33'(sc_ff[1]); end
               5'd3:  begin ma = tmp_ff;   mb = 33'(sc_ff[0]); end
               5'd4:  begin ma = sc_ff[5]; mb = 33'(sc_ff[0]); end // sz*cx
               5'd5:  begin ma = sc_ff[5]; mb = 33'(sc_ff[1]); end // sz*sx
               5'd6:  begin ma = sc_ff[5]; mb = 33'(sc_ff[2]); end // sz*cy
               5'd7:  begin ma = sc_ff[5]; mb = 33'(sc_ff[3]); end // sz*sy
               5'd8:  begin ma = tmp_ff;   mb = 33'(sc_ff[1]); end
               5'd9:  begin ma = tmp_ff;   mb = 33'(sc_ff[0]); end
               5'd10: begin ma = sc_ff[4]; mb = 33'(sc_ff[0]); end // cz*cx
               5'd11: begin ma = sc_ff[4]; mb = 33'(sc_ff[1]); end // cz*sx
               5'd12: begin ma = sc_ff[2]; mb = 33'(sc_ff[1]); end // cy*sx
               5'd13: begin ma = sc_ff[2]; mb = 33'(sc_ff[0]); end // cy*cx
               default: ;
            endcase
         end
         ST_SCALE: begin
            ridx = 4'(row) * 4'd3 + 4'(col);
            ma = rot_ff[ridx];
            mb = 33'(prm_ff[4'd6 + {2'd0, col}]);
         end
         ST_XFORM: begin
            ma = (row == 2'd3) ? ((col == 2'd3) ? ONE_Q : 32'sd0)
                               : mtx_ff[{row, col}];
            mb = 33'(vec_ff[col]);
         end
         default: ;
      endcase
   end

   assign prod = ma * mb;
   assign pq = 48'((prod + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (acc) begin
            if (req_tuser == FUNC_TRANSFORM) state_in = ST_XFORM;
            else if (sel < NUM_PARAMS)       state_in = ST_CD_INIT;
         end
         ST_CD_INIT:  state_in = ST_CORDIC;
         ST_CORDIC:   if (cnt_ff == 5'(CORDIC_STEPS - 1)) state_in = ST_SC_STORE;
         ST_SC_STORE: state_in = (axis_ff == 2'd2) ? ST_ROT : ST_CD_INIT;
         ST_ROT:      if (cnt_ff == 5'd13) state_in = ST_SCALE;
         ST_SCALE:    if (cnt_ff == 5'd10) state_in = ST_IDLE;
         ST_XFORM:    if (col == 2'd3) state_in = ST_XF_ROW;
         ST_XF_ROW:   state_in = (cnt_ff == 5'd16) ? ST_OUT : ST_XFORM;
         ST_OUT:      state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         cnt_ff <= '0;
         axis_ff <= '0;
         for (int i = 0; i < 9; i++) prm_ff[i] <= (i >= 6) ? ONE_Q : 32'sd0;
         for (int i = 0; i < 12; i++)
            mtx_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q : 32'sd0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               axis_ff <= '0;
               hi_ff <= '0;
               lo_ff <= '0;
               if (acc) begin
                  vec_ff[0] <= req_tdata[67:36];
                  vec_ff[1] <= req_tdata[99:68];
                  vec_ff[2] <= req_tdata[131:100];
                  vec_ff[3] <= req_tdata[163:132];
                  if (req_tuser == FUNC_SET && sel < NUM_PARAMS)
                     prm_ff[sel] <= req_tdata[35:4];
               end
            end
            ST_CD_INIT: begin
               q_ff <= qn;
               cx_ff <= CORDIC_GAIN_INV;
               cy_ff <= '0;
               cz_ff <= 34'(signed'(rw));
               cnt_ff <= '0;
            end
            ST_CORDIC: begin
               if (!cz_ff[33]) begin
                  cx_ff <= cx_ff - dx; cy_ff <= cy_ff + dy; cz_ff <= cz_ff - at;
               end else begin
                  cx_ff <= cx_ff + dx; cy_ff <= cy_ff - dy; cz_ff <= cz_ff + at;
               end
               cnt_ff <= cnt_ff + 5'd1;
            end
            ST_SC_STORE: begin
               sc_ff[{axis_ff, 1'b0}] <= crd_c;
               sc_ff[{axis_ff, 1'b1}] <= crd_s;
               axis_ff <= axis_ff + 2'd1;
               cnt_ff <= '0;
            end
            ST_ROT: begin
               cnt_ff <= (cnt_ff == 5'd13) ? 5'd0 : cnt_ff + 5'd1;
               case (cnt_ff)
                  5'd0:  rot_ff[0] <= pq[31:0];
                  5'd1:  tmp_ff <= pq[31:0];
                  5'd2:  rot_ff[1] <= pq[31:0];
                  5'd3:  rot_ff[2] <= pq[31:0];
                  5'd4:  rot_ff[1] <= rot_ff[1] - pq[31:0];
                  5'd5:  rot_ff[2] <= rot_ff[2] + pq[31:0];
                  5'd6:  rot_ff[3] <= pq[31:0];
                  5'd7:  tmp_ff <= pq[31:0];
                  5'd8:  rot_ff[4] <= pq[31:0];
                  5'd9:  rot_ff[5] <= pq[31:0];
                  5'd10: rot_ff[4] <= rot_ff[4] + pq[31:0];
                  5'd11: rot_ff[5] <= rot_ff[5] - pq[31:0];
                  5'd12: rot_ff[7] <= pq[31:0];
                  5'd13: begin
                     rot_ff[8] <= pq[31:0];
                     rot_ff[6] <= -sc_ff[3];
                  end
                  default: ;
               endcase
            end
            ST_SCALE: begin
               mtx_ff[{row, col}] <= sat32(50'(pq));
               if (col == 2'd2) begin
                  mtx_ff[{row, 2'd3}] <= prm_ff[{2'd0, row}];
                  cnt_ff <= {1'b0, row + 2'd1, 2'd0};
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            ST_XFORM: begin
               hi_ff <= hi_ff + 50'(prod >>> FRAC_BITS);
               lo_ff <= lo_ff + 50'({1'b0, prod[FRAC_BITS-1:0]});
               cnt_ff <= cnt_ff + 5'd1;
            end
            ST_XF_ROW: begin
               res_ff[row - 2'd1] <= sat32(hi_ff +
                  ((lo_ff + (50'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
               hi_ff <= '0;
               lo_ff <= '0;
            end
            ST_OUT: rv_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   property p_busy_not_ready;
      @(posedge clock) disable iff (reset) (state_ff != ST_IDLE) |-> !req_tready;
   endproperty
   a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

   a_out_from_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> $past(state_ff) == ST_XF_ROW)
      else $error("result without last row");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

   a_scale_after_rot: assert property (@(posedge clock) disable iff (reset)
      ($rose(state_ff == ST_SCALE)) |-> $past(state_ff) == ST_ROT)
      else $error("scale without rotation");
endmodule
`default_nettype wire
